### rtl/core/slbm_pkg.sv
// Shared types, codes and helpers for the serial loaded bank mapper.
`timescale 1ns / 1ps

package slbm_pkg;

    // Field widths fixed by the bus
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int OFFS_W   = 18;
    localparam int CFG_W    = 5;
    localparam int WIN_BYTES = 8192;     // size of the 0x6000-0x7FFF window
    localparam int MAX_PRG_BANKS = 16;

    // Serial port reload value (marker bit in the top position)
    localparam logic [4:0] SHIFT_EMPTY = 5'h10;

    typedef enum logic [1:0] {
        OP_CPU_RD = 2'd0,
        OP_CPU_WR = 2'd1,
        OP_PPU_RD = 2'd2,
        OP_PPU_WR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        TGT_NONE    = 2'd0,
        TGT_PRG_RAM = 2'd1,
        TGT_PRG_ROM = 2'd2,
        TGT_CHR     = 2'd3
    } t_target;

    // Configuration register indexes
    localparam logic CFG_PRG_BANK_COUNT = 1'b0;
    localparam logic CFG_CHR_IS_RAM     = 1'b1;

    // PRG modes (modes 0 and 1 both switch 32K)
    localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

    // Serial port register select, address bits 14:13 above 0x8000
    localparam logic [1:0] SEL_CONTROL  = 2'd0;
    localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
    localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
    localparam logic [1:0] SEL_PRG      = 2'd3;

    // Address region codes from bits 15:13
    localparam logic [2:0] REGION_PATTERN = 3'b000;
    localparam logic [2:0] REGION_PRG_RAM = 3'b011;

    typedef struct packed {
        logic             valid;
        t_op              op;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
    } t_access;

    typedef struct packed {
        logic [4:0] prg_bank_count;
        logic       chr_is_ram;
        logic [4:0] load_shift;
        logic [1:0] prg_mode;
        logic       chr_4k_mode;
        logic [1:0] mirror_mode;
        logic [4:0] chr_bank_low;
        logic [4:0] chr_bank_high;
        logic [4:0] chr_bank_8k;
        logic [3:0] prg_bank_32k;
        logic [3:0] prg_bank_low;
        logic [3:0] prg_bank_high;
    } t_bank_state;

    typedef struct packed {
        logic              handled;
        t_target           target;
        logic [OFFS_W-1:0] mem_offset;
        logic              pattern_write;
        logic [1:0]        mirroring;
    } t_result;

    typedef struct packed {
        logic rd;
        logic we;
    } t_ram_req;

    // Last 16K bank for a given count, with the count clamped to 1..MAX_PRG_BANKS
    function automatic logic [3:0] last_bank(input logic [4:0] count);
        logic [4:0] n;
        n = count;
        if (n > 5'(MAX_PRG_BANKS)) n = 5'(MAX_PRG_BANKS);
        if (n == 5'd0) n = 5'd1;
        return 4'(n - 5'd1);
    endfunction

endpackage

### rtl/core/slbm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module slbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read; read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/slbm_ctrl.sv
// Serial load port, bank registers and configuration registers.
`timescale 1ns / 1ps

module slbm_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  slbm_pkg::t_access           i_acc,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [slbm_pkg::CFG_W-1:0]  i_cfg_data,
    output slbm_pkg::t_bank_state       o_state,
    output logic [1:0]                  o_mirror_next
);

    slbm_pkg::t_bank_state r_st;
    slbm_pkg::t_bank_state n_st;
    slbm_pkg::t_bank_state rst_st;
    logic [4:0] cmd;
    logic       port_write;

    // Reset image of the register file
    always_comb begin
        rst_st                = '0;
        rst_st.prg_bank_count = 5'd2;
        rst_st.load_shift     = slbm_pkg::SHIFT_EMPTY;
        rst_st.prg_mode       = slbm_pkg::PRG_MODE_FIX_HIGH;
        rst_st.prg_bank_high  = slbm_pkg::last_bank(5'd2);
    end

    assign port_write = i_acc.valid && (i_acc.op == slbm_pkg::OP_CPU_WR)
                        && i_acc.address[15];
    assign cmd        = {i_acc.data[0], r_st.load_shift[4:1]};

    // Next register state: configuration writes, then serial port writes
    always_comb begin
        n_st = r_st;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                slbm_pkg::CFG_PRG_BANK_COUNT: begin
                    n_st.prg_bank_count = i_cfg_data;
                    n_st.prg_bank_high  = slbm_pkg::last_bank(i_cfg_data);
                end
                slbm_pkg::CFG_CHR_IS_RAM: begin
                    n_st.chr_is_ram = i_cfg_data[0];
                end
                default: ;
            endcase
        end
        if (port_write) begin
            if (i_acc.data[7]) begin
                // Reset the port and force the fixed-high PRG mode
                n_st.load_shift    = slbm_pkg::SHIFT_EMPTY;
                n_st.prg_mode      = slbm_pkg::PRG_MODE_FIX_HIGH;
                n_st.prg_bank_high = slbm_pkg::last_bank(r_st.prg_bank_count);
            end else if (!r_st.load_shift[0]) begin
                n_st.load_shift = cmd;
            end else begin
                // Fifth bit: load the register picked by the address
                n_st.load_shift = slbm_pkg::SHIFT_EMPTY;
                unique case (i_acc.address[14:13])
                    slbm_pkg::SEL_CONTROL: begin
                        n_st.mirror_mode = cmd[1:0];
                        n_st.prg_mode    = cmd[3:2];
                        n_st.chr_4k_mode = cmd[4];
                        if (cmd[3:2] == slbm_pkg::PRG_MODE_FIX_LOW) begin
                            n_st.prg_bank_low = 4'd0;
                        end else if (cmd[3:2] == slbm_pkg::PRG_MODE_FIX_HIGH) begin
                            n_st.prg_bank_high =
                                slbm_pkg::last_bank(r_st.prg_bank_count);
                        end
                    end
                    slbm_pkg::SEL_CHR_LOW: begin
                        if (r_st.chr_4k_mode) n_st.chr_bank_low = cmd;
                        else                  n_st.chr_bank_8k  = {1'b0, cmd[4:1]};
                    end
                    slbm_pkg::SEL_CHR_HIGH: begin
                        if (r_st.chr_4k_mode) n_st.chr_bank_high = cmd;
                    end
                    slbm_pkg::SEL_PRG: begin
                        if (!r_st.prg_mode[1]) begin
                            n_st.prg_bank_32k = {1'b0, cmd[3:1]};
                        end else if (r_st.prg_mode == slbm_pkg::PRG_MODE_FIX_LOW) begin
                            n_st.prg_bank_high = cmd[3:0];
                        end else begin
                            n_st.prg_bank_low = cmd[3:0];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= rst_st;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_state       = r_st;
    assign o_mirror_next = n_st.mirror_mode;

endmodule

### rtl/core/slbm_map.sv
// Address decode and bank translation for one bus access.
`timescale 1ns / 1ps

module slbm_map (
    input  slbm_pkg::t_access     i_acc,
    input  slbm_pkg::t_bank_state i_state,
    input  logic [1:0]            i_mirror_next,
    output slbm_pkg::t_result     o_res,
    output slbm_pkg::t_ram_req    o_ram
);

    logic [2:0] region;
    logic [3:0] prg_bank;
    logic [4:0] chr_bank;

    assign region   = i_acc.address[15:13];
    assign prg_bank = i_acc.address[14] ? i_state.prg_bank_high : i_state.prg_bank_low;
    assign chr_bank = i_acc.address[12] ? i_state.chr_bank_high : i_state.chr_bank_low;

    // Decode the access and form the offset from the current banks
    always_comb begin
        o_res           = '0;
        o_res.target    = slbm_pkg::TGT_NONE;
        o_res.mirroring = i_mirror_next;
        o_ram           = '0;
        if (!i_acc.op[1]) begin
            if (region == slbm_pkg::REGION_PRG_RAM) begin
                o_res.handled = 1'b1;
                o_res.target  = slbm_pkg::TGT_PRG_RAM;
                o_ram.rd      = (i_acc.op == slbm_pkg::OP_CPU_RD);
                o_ram.we      = (i_acc.op == slbm_pkg::OP_CPU_WR);
            end else if (i_acc.address[15]) begin
                o_res.handled = 1'b1;
                if (i_acc.op == slbm_pkg::OP_CPU_RD) begin
                    o_res.target = slbm_pkg::TGT_PRG_ROM;
                    if (!i_state.prg_mode[1]) begin
                        o_res.mem_offset = {i_state.prg_bank_32k[2:0],
                                            i_acc.address[14:0]};
                    end else begin
                        o_res.mem_offset = {prg_bank, i_acc.address[13:0]};
                    end
                end
            end
        end else if (region == slbm_pkg::REGION_PATTERN) begin
            if (i_acc.op == slbm_pkg::OP_PPU_WR) begin
                if (i_state.chr_is_ram) begin
                    o_res.handled       = 1'b1;
                    o_res.target        = slbm_pkg::TGT_CHR;
                    o_res.mem_offset    = {5'd0, i_acc.address[12:0]};
                    o_res.pattern_write = 1'b1;
                end
            end else begin
                o_res.handled = 1'b1;
                o_res.target  = slbm_pkg::TGT_CHR;
                if (i_state.chr_is_ram) begin
                    o_res.mem_offset = {5'd0, i_acc.address[12:0]};
                end else if (i_state.chr_4k_mode) begin
                    o_res.mem_offset = {1'b0, chr_bank, i_acc.address[11:0]};
                end else begin
                    o_res.mem_offset = {i_state.chr_bank_8k, i_acc.address[12:0]};
                end
            end
        end
    end

endmodule

### rtl/core/serial_loaded_bank_mapper.sv
// Top level of the serial loaded bank mapper: pipeline, program RAM and clearing pass.
`timescale 1ns / 1ps

// Serial loaded bank mapper. Takes one CPU or PPU bus access per clock while
// o_in_stall is low and returns one result word per access; the input side
// and the output register are parted by a pipeline stage, so an access is
// taken every cycle while the downstream side keeps up. The program RAM lives
// in a synchronous RAM with one write and one registered read port; a CPU
// write there commits at acceptance and a read returns its byte with the
// result. After reset the RAM is cleared one byte a cycle, during which
// o_in_stall stays high; configuration writes are taken at any time, and
// should be issued only while no access is in flight.

module serial_loaded_bank_mapper #(
    parameter int PRG_RAM_BYTES = 8192
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // access words in
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_op,
    input  logic [slbm_pkg::ADDR_W-1:0]   i_address,
    input  logic [slbm_pkg::DATA_W-1:0]   i_data,
    // result words out
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_handled,
    output logic [1:0]                    o_target,
    output logic [slbm_pkg::OFFS_W-1:0]   o_mem_offset,
    output logic [slbm_pkg::DATA_W-1:0]   o_read_data,
    output logic                          o_pattern_write,
    output logic [1:0]                    o_mirroring,
    // configuration
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [slbm_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int RAM_AW    = $clog2(PRG_RAM_BYTES);
    localparam int MOD_STEPS = (slbm_pkg::WIN_BYTES + PRG_RAM_BYTES - 1) / PRG_RAM_BYTES - 1;
    localparam logic [RAM_AW-1:0] RAM_LAST = RAM_AW'(PRG_RAM_BYTES - 1);
    localparam logic [12:0]       RAM_SIZE = 13'(PRG_RAM_BYTES);

    slbm_pkg::t_access     acc;
    slbm_pkg::t_bank_state state;
    slbm_pkg::t_result     res;
    slbm_pkg::t_ram_req    ram_req;
    logic [1:0]            mirror_next;

    logic                  in_acc;
    logic                  out_ready;
    logic                  s1_adv;
    logic [12:0]           win_idx;
    logic [RAM_AW-1:0]     ram_idx;
    logic                  ram_we;
    logic [RAM_AW-1:0]     ram_waddr;
    logic [slbm_pkg::DATA_W-1:0] ram_wdata;
    logic [slbm_pkg::DATA_W-1:0] ram_q;

    logic                  r_clearing;
    logic [RAM_AW-1:0]     r_clr_addr;
    logic                  r_s1_valid;
    slbm_pkg::t_result     r_s1_res;
    logic                  r_s1_rd;
    logic                  r_out_valid;
    slbm_pkg::t_result     r_out_res;
    logic [slbm_pkg::DATA_W-1:0] r_out_rdata;

    // Handshake
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_ready;
    assign o_in_stall = r_clearing || (r_s1_valid && !out_ready);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign acc.valid   = in_acc;
    assign acc.op      = slbm_pkg::t_op'(i_op);
    assign acc.address = i_address;
    assign acc.data    = i_data;

    slbm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_state       (state),
        .o_mirror_next (mirror_next)
    );

    slbm_map u_map (
        .i_acc         (acc),
        .i_state       (state),
        .i_mirror_next (mirror_next),
        .o_res         (res),
        .o_ram         (ram_req)
    );

    // Fold the 8K window onto the RAM size
    always_comb begin
        win_idx = i_address[12:0];
        for (int k = 0; k < MOD_STEPS; k++) begin
            if (win_idx >= RAM_SIZE) win_idx = win_idx - RAM_SIZE;
        end
    end
    assign ram_idx = win_idx[RAM_AW-1:0];

    // Write port: clearing pass first, then CPU writes
    assign ram_we    = r_clearing || (in_acc && ram_req.we);
    assign ram_waddr = r_clearing ? r_clr_addr : ram_idx;
    assign ram_wdata = r_clearing ? '0 : i_data;

    slbm_ram #(
        .WIDTH (slbm_pkg::DATA_W),
        .DEPTH (PRG_RAM_BYTES)
    ) u_prg_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc && ram_req.rd),
        .i_raddr (ram_idx),
        .o_rdata (ram_q)
    );

    // Sweep the RAM to zero after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == RAM_LAST) r_clearing <= 1'b0;
        end
    end

    // Stage 1: hold the mapped result while the RAM read completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_res <= res;
            r_s1_rd  <= ram_req.rd;
        end
    end

    // Output register: capture the RAM byte with the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_res   <= r_s1_res;
            r_out_rdata <= r_s1_rd ? ram_q : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_handled       = r_out_res.handled;
    assign o_target        = r_out_res.target;
    assign o_mem_offset    = r_out_res.mem_offset;
    assign o_read_data     = r_out_rdata;
    assign o_pattern_write = r_out_res.pattern_write;
    assign o_mirroring     = r_out_res.mirroring;

    // No access may enter while the RAM is being cleared
    a_no_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !in_acc)
        else $error("access accepted during RAM clearing pass");

    // A RAM byte only shows up on program RAM results
    a_rdata_ram: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_rdata != '0)) |-> (r_out_res.target == slbm_pkg::TGT_PRG_RAM))
        else $error("read data on a result that is not a program RAM read");

    // Pattern writes are always claimed pattern accesses
    a_pwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.pattern_write)
            |-> (r_out_res.handled && (r_out_res.target == slbm_pkg::TGT_CHR)))
        else $error("pattern write on an unclaimed or non-pattern result");

    // A result stuck in stage 1 keeps the RAM read data steady
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> $stable(ram_q))
        else $error("RAM read data changed under a waiting stage 1 word");

endmodule

### tb/tb.sv
// Testbench for the serial loaded bank mapper: directed and random bus traffic with a scoreboard.
`timescale 1ns / 1ps

module tb;
    import slbm_pkg::*;

    localparam int RAM_BYTES   = 8192;
    localparam int QUIET_LIMIT = 50000;  // covers the RAM clearing pass after reset
    localparam int DRAIN_CYCLES = 10;
    localparam int BURST_WORDS = 120;

    typedef struct packed {
        logic              handled;
        t_target           target;
        logic [OFFS_W-1:0] mem_offset;
        logic [DATA_W-1:0] read_data;
        logic              pattern_write;
        logic [1:0]        mirroring;
    } t_bus_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [1:0]           i_op;
    logic [ADDR_W-1:0]    i_address;
    logic [DATA_W-1:0]    i_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_handled;
    logic [1:0]           o_target;
    logic [OFFS_W-1:0]    o_mem_offset;
    logic [DATA_W-1:0]    o_read_data;
    logic                 o_pattern_write;
    logic [1:0]           o_mirroring;
    logic                 i_cfg_we;
    logic                 i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    // Mapper state mirrored by the predictor
    logic [4:0]           bank_count;
    logic                 pattern_is_ram;
    logic [4:0]           shift_reg;
    logic [1:0]           prg_mode;
    logic                 chr_4k;
    logic [1:0]           mirror;
    logic [4:0]           chr_lo;
    logic [4:0]           chr_hi;
    logic [4:0]           chr_8k;
    logic [3:0]           prg_32k;
    logic [3:0]           prg_lo;
    logic [3:0]           prg_hi;
    logic [7:0]           prg_ram [RAM_BYTES];

    t_bus_result          pending_results[$];
    t_bus_result          want_word;
    int                   fail_count;
    int                   words_sent;
    int                   quiet_cycles;
    int                   access_gap_pct;
    int                   result_stall_pct;

    serial_loaded_bank_mapper #(
        .PRG_RAM_BYTES(RAM_BYTES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_address      (i_address),
        .i_data         (i_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_handled      (o_handled),
        .o_target       (o_target),
        .o_mem_offset   (o_mem_offset),
        .o_read_data    (o_read_data),
        .o_pattern_write(o_pattern_write),
        .o_mirroring    (o_mirroring),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Highest 16K bank; counts past the maximum saturate, zero acts as one
    function automatic logic [3:0] final_bank(input logic [4:0] count);
        if (count == 5'd0)
            return 4'd0;
        else if (count >= 5'(MAX_PRG_BANKS))
            return 4'(MAX_PRG_BANKS - 1);
        else
            return 4'(count - 5'd1);
    endfunction

    function automatic void reset_model();
        bank_count     = 5'd2;
        pattern_is_ram = 1'b0;
        mirror         = 2'd0;
        chr_4k         = 1'b0;
        chr_lo         = '0;
        chr_hi         = '0;
        chr_8k         = '0;
        prg_32k        = '0;
        prg_lo         = '0;
        shift_reg      = SHIFT_EMPTY;
        prg_mode       = PRG_MODE_FIX_HIGH;
        prg_hi         = final_bank(bank_count);
        foreach (prg_ram[i]) prg_ram[i] = 8'h00;
    endfunction

    // Shift one bit into the serial port and load a register on every fifth write
    function automatic void shift_in(input logic [ADDR_W-1:0] addr, input logic [7:0] dat);
        logic [4:0] cmd;
        cmd = {dat[0], shift_reg[4:1]};
        if (dat[7]) begin
            shift_reg = SHIFT_EMPTY;
            prg_mode  = PRG_MODE_FIX_HIGH;
            prg_hi    = final_bank(bank_count);
        end else if (!shift_reg[0]) begin
            shift_reg = cmd;
        end else begin
            shift_reg = SHIFT_EMPTY;
            case (addr[14:13])
                SEL_CONTROL: begin
                    mirror   = cmd[1:0];
                    prg_mode = cmd[3:2];
                    if (prg_mode == PRG_MODE_FIX_LOW)
                        prg_lo = 4'd0;
                    else if (prg_mode == PRG_MODE_FIX_HIGH)
                        prg_hi = final_bank(bank_count);
                    chr_4k = cmd[4];
                end
                SEL_CHR_LOW: begin
                    if (chr_4k) chr_lo = cmd;
                    else chr_8k = {1'b0, cmd[4:1]};
                end
                SEL_CHR_HIGH: begin
                    // 8K mode drops the high register load
                    if (chr_4k) chr_hi = cmd;
                end
                SEL_PRG: begin
                    if (prg_mode < PRG_MODE_FIX_LOW) prg_32k = {1'b0, cmd[3:1]};
                    else if (prg_mode == PRG_MODE_FIX_LOW) prg_hi = cmd[3:0];
                    else prg_lo = cmd[3:0];
                end
            endcase
        end
    endfunction

    // Predict the result word of one access and advance the mapper state
    function automatic t_bus_result map_access(input t_op op, input logic [ADDR_W-1:0] addr,
                                               input logic [7:0] dat);
        t_bus_result res;
        int unsigned off;
        res = '0;
        off = 0;
        if (op == OP_CPU_RD || op == OP_CPU_WR) begin
            if (addr >= 16'h6000 && addr < 16'h8000) begin
                res.handled = 1'b1;
                res.target  = TGT_PRG_RAM;
                if (op == OP_CPU_RD)
                    res.read_data = prg_ram[int'(addr[12:0]) % RAM_BYTES];
                else
                    prg_ram[int'(addr[12:0]) % RAM_BYTES] = dat;
            end else if (addr[15]) begin
                res.handled = 1'b1;
                if (op == OP_CPU_WR) begin
                    shift_in(addr, dat);
                end else begin
                    res.target = TGT_PRG_ROM;
                    if (prg_mode < PRG_MODE_FIX_LOW)
                        off = prg_32k * 32'h8000 + addr[14:0];
                    else if (!addr[14])
                        off = prg_lo * 32'h4000 + addr[13:0];
                    else
                        off = prg_hi * 32'h4000 + addr[13:0];
                end
            end
        end else if (addr <= 16'h1FFF) begin
            if (op == OP_PPU_WR) begin
                // Pattern ROM is never written
                if (pattern_is_ram) begin
                    res.handled       = 1'b1;
                    res.target        = TGT_CHR;
                    res.pattern_write = 1'b1;
                    off = addr;
                end
            end else begin
                res.handled = 1'b1;
                res.target  = TGT_CHR;
                if (pattern_is_ram)
                    off = addr;
                else if (chr_4k)
                    off = (addr[12] ? chr_hi : chr_lo) * 32'h1000 + addr[11:0];
                else
                    off = chr_8k * 32'h2000 + addr;
            end
        end
        res.mem_offset = off[OFFS_W-1:0];
        res.mirroring  = mirror;
        return res;
    endfunction

    // Present one access word, hold it until taken, then log its prediction
    task automatic send_access(input t_op op, input logic [ADDR_W-1:0] addr,
                               input logic [7:0] dat);
        if ($urandom_range(0, 99) < access_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < access_gap_pct);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_address  <= addr;
        i_data     <= dat;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(map_access(op, addr, dat));
        words_sent++;
    endtask

    // Shift a 5-bit value into the serial port, LSB first
    task automatic load_register(input logic [ADDR_W-1:0] addr, input logic [4:0] value);
        for (int i = 0; i < 5; i++)
            send_access(OP_CPU_WR, addr, {1'b0, 6'($urandom), value[i]});
    endtask

    // Drop valid and wait until every result word has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic cfg_write(input logic idx, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_PRG_BANK_COUNT) begin
            bank_count = value;
            prg_hi     = final_bank(value);
        end else begin
            pattern_is_ram = value[0];
        end
    endtask

    // Power-on banking: fixed high bank, 8K pattern bank 0, unclaimed regions
    task automatic test_power_on_map();
        send_access(OP_CPU_RD, 16'h8000, 8'h00);
        send_access(OP_CPU_RD, 16'hFFFF, 8'hFF);
        send_access(OP_PPU_RD, 16'h1FFF, 8'h00);
        send_access(OP_CPU_RD, 16'h5FFF, 8'hFF);
        send_access(OP_PPU_WR, 16'h0000, 8'hFF);
    endtask

    // Program RAM: cleared contents at 0x6000, write then read back at 0x7FFF
    task automatic test_prg_ram();
        send_access(OP_CPU_WR, 16'h7FFF, 8'hFF);
        send_access(OP_CPU_RD, 16'h7FFF, 8'h00);
        send_access(OP_CPU_RD, 16'h6000, 8'h00);
    endtask

    // Serial port: partial load broken by a reset write, then full loads
    task automatic test_serial_port();
        send_access(OP_CPU_WR, 16'h8000, 8'h01);
        send_access(OP_CPU_WR, 16'h8000, 8'h00);
        send_access(OP_CPU_WR, 16'hFFFF, 8'h80);
        load_register(16'h9FFF, 5'h1F);
        load_register(16'hA000, 5'h1F);
        send_access(OP_PPU_RD, 16'h0FFF, 8'h00);
        send_access(OP_CPU_RD, 16'hBFFF, 8'h00);
    endtask

    // Pattern RAM: writes claimed below 0x2000 only
    task automatic test_chr_ram();
        settle();
        cfg_write(CFG_CHR_IS_RAM, 5'd1);
        send_access(OP_PPU_WR, 16'h1FFF, 8'hA5);
        send_access(OP_PPU_WR, 16'h2000, 8'h5A);
        send_access(OP_PPU_RD, 16'h0000, 8'h00);
    endtask

    // One random stretch of traffic, mostly well-formed register loads and single accesses
    task automatic random_burst();
        int           pick;
        int           cut;
        logic [15:0]  addr;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            load_register(16'($urandom_range(16'h8000, 16'hFFFF)), 5'($urandom));
        end else if (pick < 80) begin
            case ($urandom_range(0, 3))
                0: send_access(OP_CPU_RD, 16'($urandom_range(16'h6000, 16'hFFFF)), 8'($urandom));
                1: send_access(OP_CPU_WR, 16'($urandom_range(16'h6000, 16'h7FFF)), 8'($urandom));
                2: send_access(OP_PPU_RD, 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
                default: send_access(OP_PPU_WR, 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
            endcase
        end else if (pick < 90) begin
            // Broken load: one to four bits, then a reset write
            cut = $urandom_range(1, 4);
            for (int i = 0; i < cut; i++) begin
                addr = 16'($urandom_range(16'h8000, 16'hFFFF));
                send_access(OP_CPU_WR, addr, {1'b0, 7'($urandom)});
            end
            send_access(OP_CPU_WR, 16'($urandom_range(16'h8000, 16'hFFFF)),
                        8'($urandom) | 8'h80);
        end else begin
            send_access(t_op'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
        end
    endtask

    // Random traffic under one idling pattern and two configuration settings
    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input logic [4:0] count_a, input logic [4:0] count_b,
                                       input logic ram_a);
        int start;
        for (int s = 0; s < 2; s++) begin
            settle();
            access_gap_pct   = gap_pct;
            result_stall_pct = stall_pct;
            cfg_write(CFG_PRG_BANK_COUNT, (s == 0) ? count_a : count_b);
            cfg_write(CFG_CHR_IS_RAM, 5'(ram_a ^ s[0]));
            start = words_sent;
            while (words_sent - start < BURST_WORDS) random_burst();
        end
    endtask

    // Check each result word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with no access pending");
                fail_count++;
            end else begin
                want_word = pending_results.pop_front();
                if (o_handled !== want_word.handled) begin
                    $error("handled: expected %0d, got %0d", want_word.handled, o_handled);
                    fail_count++;
                end
                if (o_target !== want_word.target) begin
                    $error("target: expected %0d, got %0d", want_word.target, o_target);
                    fail_count++;
                end
                if (o_mem_offset !== want_word.mem_offset) begin
                    $error("mem_offset: expected 0x%05h, got 0x%05h",
                           want_word.mem_offset, o_mem_offset);
                    fail_count++;
                end
                if (o_read_data !== want_word.read_data) begin
                    $error("read_data: expected 0x%02h, got 0x%02h",
                           want_word.read_data, o_read_data);
                    fail_count++;
                end
                if (o_pattern_write !== want_word.pattern_write) begin
                    $error("pattern_write: expected %0d, got %0d",
                           want_word.pattern_write, o_pattern_write);
                    fail_count++;
                end
                if (o_mirroring !== want_word.mirroring) begin
                    $error("mirroring: expected %0d, got %0d", want_word.mirroring, o_mirroring);
                    fail_count++;
                end
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < result_stall_pct);
    end

    // End the run when no word moves for too long
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_op             = OP_CPU_RD;
        i_address        = '0;
        i_data           = '0;
        i_out_stall      = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_PRG_BANK_COUNT;
        i_cfg_data       = '0;
        fail_count       = 0;
        words_sent       = 0;
        access_gap_pct   = 0;
        result_stall_pct = 0;
        reset_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_on_map();
        test_prg_ram();
        test_serial_port();
        test_chr_ram();
        test_random_traffic(0, 0, 5'd1, 5'd16, 1'b0);
        test_random_traffic(46, 0, 5'd0, 5'd31, 1'b1);
        test_random_traffic(0, 46, 5'd17, 5'($urandom_range(1, 16)), 1'b0);
        test_random_traffic(35, 35, 5'($urandom_range(0, 31)), 5'd2, 1'b1);

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d result words never arrived", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
